/* design/mfd_pkg.sv */
`default_nettype none
package mfd_pkg;

    localparam int unsigned DATA_SIZE  = 8;
    localparam int unsigned FRAME_SIZE = 18;
    localparam int unsigned HALF_SIZE  = 9;

    localparam logic [7:0] START_RST  = 8'hAA;
    localparam logic [7:0] MIDDLE_RST = 8'hAB;
    localparam logic [7:0] FAULT_RST  = 8'hF0;

    typedef enum logic [1:0] {
        REG_START  = 2'd0,
        REG_MIDDLE = 2'd1,
        REG_FAULT  = 2'd2
    } t_reg_idx;

    typedef enum logic {
        STATUS_OK    = 1'b0,
        STATUS_FAULT = 1'b1
    } t_status;

    // entry k holds the byte k+1 steps back
    typedef logic [7:0] t_window [FRAME_SIZE];

    typedef struct packed {
        logic        found;
        t_status     status;
        logic [15:0] current;
        logic [15:0] voltage;
        logic [31:0] energy;
    } t_frame;

endpackage
`default_nettype wire

/* design/mfd_cell.sv */
`default_nettype none
module mfd_cell (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_valid,
    output logic      [7:0] o_byte,
    output logic            o_valid
);

    logic [7:0] r_byte;
    logic       r_valid;

    // byte needs no reset: the valid flag gates any frame match
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

/* design/mfd_match.sv */
`default_nettype none
module mfd_match (
    input  wire mfd_pkg::t_window i_window,
    input  wire logic             i_full,
    input  wire logic [7:0]       i_new_byte,
    input  wire logic [7:0]       i_start_marker,
    input  wire logic [7:0]       i_middle_marker,
    input  wire logic [7:0]       i_fault_byte,
    output mfd_pkg::t_frame       o_frame
);
    import mfd_pkg::*;

    logic [7:0]           w_data [DATA_SIZE];
    logic [DATA_SIZE-1:0] w_same;
    logic                 w_markers;

    // data byte j is DATA_SIZE-j back, its copy HALF_SIZE further back
    always_comb begin
        for (int j = 0; j < DATA_SIZE; j++) begin
            w_data[j] = i_window[DATA_SIZE - 1 - j];
            w_same[j] = (i_window[DATA_SIZE - 1 - j] ==
                         i_window[HALF_SIZE + DATA_SIZE - 1 - j]);
        end
    end

    assign w_markers = i_full
                    && (i_new_byte == i_start_marker)
                    && (i_window[HALF_SIZE - 1] == i_middle_marker)
                    && (i_window[FRAME_SIZE - 1] == i_start_marker);

    always_comb begin
        o_frame.found = w_markers && (&w_same);
        if (w_data[0] == i_fault_byte) begin
            o_frame.status  = STATUS_FAULT;
            o_frame.current = '0;
            o_frame.voltage = '0;
            o_frame.energy  = '0;
        end else begin
            o_frame.status  = STATUS_OK;
            o_frame.current = {w_data[0], w_data[1]};
            o_frame.voltage = {w_data[2], w_data[3]};
            o_frame.energy  = {w_data[4], w_data[5], w_data[6], w_data[7]};
        end
    end

endmodule
`default_nettype wire

/* design/meter_frame_deframer.sv */
`default_nettype none
// channel   | valid   | ready   | payload
// ----------+---------+---------+--------------------------------------------
// byte in   | i_valid | o_ready | i_rx_byte
// result    | o_valid | i_ready | o_status o_current o_voltage o_energy
// config    | i_cfg_we| -       | i_cfg_index i_cfg_data
//
// one byte per cycle while o_ready is high; a result appears in the cycle
// after the closing byte. the 18-cell chain shifts on every accepted byte.
// reset empties the chain; no frame is seen until 18 bytes have entered.
// o_ready is low only while a result is held and i_ready is low.
module meter_frame_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_status,
    output logic      [15:0] o_current,
    output logic      [15:0] o_voltage,
    output logic      [31:0] o_energy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import mfd_pkg::*;

    logic [7:0]            r_start_marker;
    logic [7:0]            r_middle_marker;
    logic [7:0]            r_fault_byte;
    logic                  w_accept;
    t_window               w_window;
    logic [FRAME_SIZE-1:0] w_valid;
    t_frame                w_frame;
    logic                  r_out_valid;
    logic                  r_status;
    logic [15:0]           r_current;
    logic [15:0]           r_voltage;
    logic [31:0]           r_energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker  <= START_RST;
            r_middle_marker <= MIDDLE_RST;
            r_fault_byte    <= FAULT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START:  r_start_marker  <= i_cfg_data;
                REG_MIDDLE: r_middle_marker <= i_cfg_data;
                REG_FAULT:  r_fault_byte    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    generate
        for (genvar k = 0; k < FRAME_SIZE; k++) begin : g_cell
            if (k == 0) begin : g_head
                mfd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_accept),
                    .i_byte  (i_rx_byte),
                    .i_valid (1'b1),
                    .o_byte  (w_window[k]),
                    .o_valid (w_valid[k])
                );
            end else begin : g_body
                mfd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_accept),
                    .i_byte  (w_window[k-1]),
                    .i_valid (w_valid[k-1]),
                    .o_byte  (w_window[k]),
                    .o_valid (w_valid[k])
                );
            end
        end
    endgenerate

    mfd_match u_match (
        .i_window        (w_window),
        .i_full          (w_valid[FRAME_SIZE-1]),
        .i_new_byte      (i_rx_byte),
        .i_start_marker  (r_start_marker),
        .i_middle_marker (r_middle_marker),
        .i_fault_byte    (r_fault_byte),
        .o_frame         (w_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= w_accept && w_frame.found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && w_accept && w_frame.found) begin
            r_status  <= w_frame.status;
            r_current <= w_frame.current;
            r_voltage <= w_frame.voltage;
            r_energy  <= w_frame.energy;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_current = r_current;
    assign o_voltage = r_voltage;
    assign o_energy  = r_energy;

    // fault result carries zero fields
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == STATUS_FAULT) |->
            (r_current == '0 && r_voltage == '0 && r_energy == '0))
        else $error("fault result with nonzero fields");

    // a frame is only found on a full chain
    a_found_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame.found |-> w_valid[FRAME_SIZE-1])
        else $error("frame found before chain filled");

    // chain fills from the head, so a valid tail means all cells valid
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[FRAME_SIZE-1] |-> (&w_valid))
        else $error("chain valid flags out of order");

    // accepted byte lands in the head cell
    a_head_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_window[0] == $past(i_rx_byte) && w_valid[0]))
        else $error("head cell did not take accepted byte");

    // a held result is not replaced while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && !$past(w_accept)))
        else $error("result dropped or byte taken while stalled");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import mfd_pkg::*;

    localparam int          HALF_PERIOD    = 2;
    localparam int          RESET_CYCLES   = 4;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          NUM_PHASES     = 6;
    localparam int          PHASE_BYTES    = 105;
    localparam int          PHASE_READINGS = 5;
    localparam logic [1:0]  REG_SPARE      = 2'd3;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_LISTED
    } t_row_kind;

    typedef struct packed {
        logic [7:0] rx;
        logic [4:0] reps;
        t_row_kind  kind;
        t_frame     listed;
    } t_dir_row;

    localparam t_frame FAULT_READING = '{found: 1'b1, status: STATUS_FAULT,
                                         current: 16'h0, voltage: 16'h0, energy: 32'h0};

    // markers and fault byte are all zero while this table runs
    localparam int DIR_ROWS = 4;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // every check matches on the zeroed window, but it is not yet full
        '{rx: 8'h00, reps: 5'd18, kind: ROW_QUIET,  listed: '0},
        // first data byte equals the fault byte
        '{rx: 8'h00, reps: 5'd1,  kind: ROW_LISTED, listed: FAULT_READING},
        '{rx: 8'hFF, reps: 5'd1,  kind: ROW_QUIET,  listed: '0},
        // markers in place but the last data byte of the copies disagrees
        '{rx: 8'h00, reps: 5'd1,  kind: ROW_QUIET,  listed: '0}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_ready     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [7:0]  i_cfg_data  = 8'h00;
    logic        o_ready;
    logic        o_valid;
    logic        o_status;
    logic [15:0] o_current;
    logic [15:0] o_voltage;
    logic [31:0] o_energy;

    // shadow of the block state and registers
    logic [7:0]  shadow_win [FRAME_SIZE];
    int unsigned shadow_fill = 0;
    logic [7:0]  cfg_start   = START_RST;
    logic [7:0]  cfg_middle  = MIDDLE_RST;
    logic [7:0]  cfg_fault   = FAULT_RST;

    t_frame      due_readings [$];
    int unsigned bytes_in           = 0;
    int unsigned readings_out       = 0;
    int unsigned readings_predicted = 0;
    int unsigned mismatches         = 0;
    int unsigned quiet_cycles       = 0;
    bit          no_gaps            = 1'b0;

    meter_frame_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_current   (o_current),
        .o_voltage   (o_voltage),
        .o_energy    (o_energy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= no_gaps || ($urandom_range(99) >= 14);
    end

    // pushes one byte through the shadow window and returns the frame it closes
    function automatic t_frame decode_byte(input logic [7:0] b);
        t_frame     r;
        logic [7:0] d [DATA_SIZE];
        logic       same;
        r    = '0;
        same = 1'b1;
        if (shadow_fill >= FRAME_SIZE && b == cfg_start &&
                shadow_win[HALF_SIZE-1] == cfg_middle &&
                shadow_win[FRAME_SIZE-1] == cfg_start) begin
            for (int j = 0; j < DATA_SIZE; j++) begin
                d[j] = shadow_win[DATA_SIZE-1-j];
                if (d[j] != shadow_win[FRAME_SIZE-2-j]) same = 1'b0;
            end
            r.found = same;
            if (same && d[0] == cfg_fault) begin
                r.status = STATUS_FAULT;
            end else if (same) begin
                r.status  = STATUS_OK;
                r.current = {d[0], d[1]};
                r.voltage = {d[2], d[3]};
                r.energy  = {d[4], d[5], d[6], d[7]};
            end
        end
        for (int k = FRAME_SIZE-1; k > 0; k--) shadow_win[k] = shadow_win[k-1];
        shadow_win[0] = b;
        if (shadow_fill < FRAME_SIZE) shadow_fill++;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input t_row_kind kind, input t_frame listed);
        t_frame guess;
        int unsigned target;
        guess = decode_byte(b);
        if (guess.found) readings_predicted++;
        if (kind == ROW_PREDICT && guess.found) begin
            due_readings.push_back(guess);
        end else if (kind == ROW_LISTED) begin
            due_readings.push_back(listed);
        end
        while (!no_gaps && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        target    = bytes_in + 1;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(negedge i_clk); while (bytes_in != target);
    endtask

    task automatic set_regs(input logic [7:0] s, input logic [7:0] m, input logic [7:0] f,
                            input bit stray);
        i_valid <= 1'b0;
        while (due_readings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_START;
        i_cfg_data  <= s;
        @(negedge i_clk);
        i_cfg_index <= REG_MIDDLE;
        i_cfg_data  <= m;
        @(negedge i_clk);
        i_cfg_index <= REG_FAULT;
        i_cfg_data  <= f;
        @(negedge i_clk);
        // unused slot, must leave every register alone
        if (stray) begin
            i_cfg_index <= REG_SPARE;
            i_cfg_data  <= 8'($urandom);
            @(negedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        cfg_start  = s;
        cfg_middle = m;
        cfg_fault  = f;
    endtask

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n) begin
            if (i_valid && o_ready) bytes_in++;
            if (o_valid && i_ready) begin
                readings_out++;
                if (due_readings.size() == 0) begin
                    $error("unexpected reading: status %0d current %h voltage %h energy %h",
                           o_status, o_current, o_voltage, o_energy);
                    mismatches++;
                end else begin
                    want = due_readings.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_current !== want.current) begin
                        $error("current: expected %h, got %h", want.current, o_current);
                        mismatches++;
                    end
                    if (o_voltage !== want.voltage) begin
                        $error("voltage: expected %h, got %h", want.voltage, o_voltage);
                        mismatches++;
                    end
                    if (o_energy !== want.energy) begin
                        $error("energy: expected %h, got %h", want.energy, o_energy);
                        mismatches++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[meter_frame_deframer] ERROR");
        $finish;
    end

    initial begin
        logic [7:0]  new_start;
        logic [7:0]  new_middle;
        logic [7:0]  new_fault;
        logic [7:0]  payload [DATA_SIZE];
        logic [7:0]  burst [$];
        logic [7:0]  noise;
        int unsigned flaw;
        int unsigned mark_bytes;
        int unsigned mark_reads;

        for (int k = 0; k < FRAME_SIZE; k++) shadow_win[k] = 8'h00;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_regs(8'h00, 8'h00, 8'h00, 1'b1);
        foreach (DIR_TAB[r]) begin
            repeat (DIR_TAB[r].reps) send_byte(DIR_TAB[r].rx, DIR_TAB[r].kind, DIR_TAB[r].listed);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            new_start  = 8'($urandom);
            new_middle = 8'($urandom);
            new_fault  = 8'($urandom);
            case (p)
                0: begin
                    new_start  = START_RST;
                    new_middle = MIDDLE_RST;
                    new_fault  = FAULT_RST;
                end
                1: begin
                    new_start  = 8'h00;
                    new_middle = 8'hFF;
                    new_fault  = 8'h00;
                end
                2: begin
                    new_start  = 8'hFF;
                    new_middle = 8'h00;
                    new_fault  = 8'hFF;
                end
                4: new_middle = new_start;
                default: ;
            endcase
            set_regs(new_start, new_middle, new_fault, $urandom_range(1));
            no_gaps    = (p == 2);
            mark_bytes = bytes_in;
            mark_reads = readings_predicted;
            while (bytes_in - mark_bytes < PHASE_BYTES ||
                   readings_predicted - mark_reads < PHASE_READINGS) begin
                if ($urandom_range(9) < 8) begin
                    // well-formed frame, sometimes damaged
                    for (int j = 0; j < DATA_SIZE; j++) begin
                        case ($urandom_range(7))
                            0:       payload[j] = 8'h00;
                            1:       payload[j] = 8'hFF;
                            default: payload[j] = 8'($urandom);
                        endcase
                    end
                    if ($urandom_range(3) == 0) payload[0] = cfg_fault;
                    flaw = $urandom_range(11);
                    burst.delete();
                    burst.push_back(cfg_start);
                    foreach (payload[j]) burst.push_back(payload[j]);
                    burst.push_back(flaw == 1 ? cfg_middle ^ 8'($urandom_range(255, 1))
                                              : cfg_middle);
                    foreach (payload[j]) burst.push_back(payload[j]);
                    if (flaw == 0) begin
                        burst[HALF_SIZE + 1 + $urandom_range(DATA_SIZE - 1)] ^=
                            8'($urandom_range(255, 1));
                    end
                    if (flaw == 2) begin
                        repeat ($urandom_range(FRAME_SIZE - 2, 1)) void'(burst.pop_back());
                    end
                    foreach (burst[k]) send_byte(burst[k], ROW_PREDICT, '0);
                end else begin
                    repeat ($urandom_range(12, 1)) begin
                        case ($urandom_range(5))
                            0:       noise = cfg_start;
                            1:       noise = cfg_middle;
                            2:       noise = cfg_fault;
                            default: noise = 8'($urandom);
                        endcase
                        send_byte(noise, ROW_PREDICT, '0);
                    end
                end
            end
            // close the last frame of the phase
            send_byte(cfg_start, ROW_PREDICT, '0);
        end

        i_valid <= 1'b0;
        no_gaps = 1'b0;
        while (due_readings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d bytes in, %0d readings out, over %0d register settings",
                 bytes_in, readings_out, NUM_PHASES + 1);
        $display("covered window fill, fault frames, damaged copies and truncated frames");
        if (mismatches == 0 && due_readings.size() == 0) begin
            $display("[meter_frame_deframer] OK");
        end else begin
            $display("[meter_frame_deframer] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
design/mfd_pkg.sv
design/mfd_cell.sv
design/mfd_match.sv
design/meter_frame_deframer.sv
tb/sv/tb_top.sv
